// ===== hdl/alu16_pkg.sv =====
`default_nettype none
package alu16_pkg;

   localparam int unsigned WordWidth = 16;
   localparam int unsigned ModeWidth = 4;
   localparam int unsigned AmtWidth  = 4;

   localparam logic [ModeWidth-1:0] MODE_ADD = 4'd0;
   localparam logic [ModeWidth-1:0] MODE_SUB = 4'd1;
   localparam logic [ModeWidth-1:0] MODE_MUL = 4'd2;
   localparam logic [ModeWidth-1:0] MODE_DIV = 4'd3;
   localparam logic [ModeWidth-1:0] MODE_MOD = 4'd4;
   localparam logic [ModeWidth-1:0] MODE_AND = 4'd5;
   localparam logic [ModeWidth-1:0] MODE_OR  = 4'd6;
   localparam logic [ModeWidth-1:0] MODE_XOR = 4'd7;
   localparam logic [ModeWidth-1:0] MODE_NOT = 4'd8;
   localparam logic [ModeWidth-1:0] MODE_SHL = 4'd9;
   localparam logic [ModeWidth-1:0] MODE_SHR = 4'd10;

   typedef struct packed {
      logic [ModeWidth-1:0] mode;
      logic [WordWidth-1:0] operand_a;
      logic [WordWidth-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [WordWidth-1:0] result;
      logic                 zero_flag;
      logic                 negative_flag;
      logic                 carry_flag;
      logic                 overflow_flag;
   } rsp_type;

   // partial division state carried between stages
   typedef struct packed {
      logic [WordWidth-1:0] rem;
      logic [WordWidth-1:0] quo;
      logic [WordWidth-1:0] dvs;
   } div_type;

endpackage
`default_nettype wire

// ===== hdl/alu16_with_flags_core.sv =====
`default_nettype none
// 16-bit ALU with zero, negative, carry and overflow flags. One operation is
// taken per cycle (busy is always low) and its result appears on rsp_* with
// rsp_valid once it has passed the four pipeline registers and the output
// register. The restoring divider has four stages, four quotient bits each,
// and all operations travel through the same pipeline so results stay in order.
// The receiver cannot stall; each result is shown for one cycle only.
module alu16_with_flags_core (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  wire alu16_pkg::req_type req_data,
   output logic                rsp_valid,
   output alu16_pkg::rsp_type  rsp_data
);

   localparam int unsigned Depth = 4;

   logic                   valid_ff [Depth];
   alu16_pkg::req_type     req_ff   [Depth];
   logic [15:0]            fast_ff  [Depth];
   logic                   carry_ff [Depth];
   logic                   ovf_ff   [Depth];

   logic [15:0] fast_in;
   logic        carry_in;
   logic        ovf_in;
   logic [16:0] sum;
   logic [31:0] prod;
   logic [3:0]  amt;
   logic [31:0] shl_w;

   alu16_pkg::div_type div_res;
   alu16_pkg::rsp_type rsp_in;
   logic               rsp_valid_ff;
   alu16_pkg::rsp_type rsp_ff;
   logic               fire;

   assign busy = 1'b0;
   assign fire = start && !busy;

   // stage 0: everything but divide
   always_comb begin
      amt      = req_data.operand_b[3:0];
      sum      = '0;
      prod     = req_data.operand_a * req_data.operand_b;
      shl_w    = {16'd0, req_data.operand_a} << amt;
      fast_in  = '0;
      carry_in = 1'b0;
      ovf_in   = 1'b0;
      case (req_data.mode)
         alu16_pkg::MODE_ADD: begin
            sum      = {1'b0, req_data.operand_a} + {1'b0, req_data.operand_b};
            fast_in  = sum[15:0];
            carry_in = sum[16];
            ovf_in   = ~(req_data.operand_a[15] ^ req_data.operand_b[15])
                       & (req_data.operand_a[15] ^ sum[15]);
         end
         alu16_pkg::MODE_SUB: begin
            sum      = {1'b0, req_data.operand_a} - {1'b0, req_data.operand_b};
            fast_in  = sum[15:0];
            carry_in = sum[16];
            ovf_in   = (req_data.operand_a[15] ^ req_data.operand_b[15])
                       & (req_data.operand_a[15] ^ sum[15]);
         end
         alu16_pkg::MODE_MUL: begin
            fast_in  = prod[15:0];
            carry_in = |prod[31:16];
         end
         alu16_pkg::MODE_AND: fast_in = req_data.operand_a & req_data.operand_b;
         alu16_pkg::MODE_OR:  fast_in = req_data.operand_a | req_data.operand_b;
         alu16_pkg::MODE_XOR: fast_in = req_data.operand_a ^ req_data.operand_b;
         alu16_pkg::MODE_NOT: fast_in = ~req_data.operand_a;
         alu16_pkg::MODE_SHL: begin
            fast_in  = shl_w[15:0];
            carry_in = (amt != 4'd0) && shl_w[16];
         end
         alu16_pkg::MODE_SHR: begin
            fast_in  = req_data.operand_a >> amt;
            carry_in = (amt != 4'd0) && req_data.operand_a[amt - 4'd1];
         end
         default: fast_in = '0;
      endcase
   end

   alu16_div_pipe #(.StepsPerStage(4)) u_div (
      .clock    (clock),
      .enable   (1'b1),
      .dividend (req_data.operand_a),
      .divisor  (req_data.operand_b),
      .div_out  (div_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Depth; k++) valid_ff[k] <= 1'b0;
      end else begin
         valid_ff[0] <= fire;
         for (int k = 1; k < Depth; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      req_ff[0]   <= req_data;
      fast_ff[0]  <= fast_in;
      carry_ff[0] <= carry_in;
      ovf_ff[0]   <= ovf_in;
      for (int k = 1; k < Depth; k++) begin
         req_ff[k]   <= req_ff[k-1];
         fast_ff[k]  <= fast_ff[k-1];
         carry_ff[k] <= carry_ff[k-1];
         ovf_ff[k]   <= ovf_ff[k-1];
      end
   end

   always_comb begin
      rsp_in.result        = fast_ff[Depth-1];
      rsp_in.carry_flag    = carry_ff[Depth-1];
      rsp_in.overflow_flag = ovf_ff[Depth-1];
      if (req_ff[Depth-1].mode == alu16_pkg::MODE_DIV) begin
         rsp_in.result = (req_ff[Depth-1].operand_b == '0) ? '0 : div_res.quo;
      end else if (req_ff[Depth-1].mode == alu16_pkg::MODE_MOD) begin
         rsp_in.result = (req_ff[Depth-1].operand_b == '0) ? '0 : div_res.rem;
      end
      rsp_in.zero_flag     = (rsp_in.result == '0);
      rsp_in.negative_flag = rsp_in.result[15];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff[Depth-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      valid_ff[Depth-1] |=> rsp_valid)
      else $error("result lost at output stage");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[Depth-1] |=> !rsp_valid)
      else $error("result without operation");

   a_zero_div: assert property (@(posedge clock) disable iff (reset)
      valid_ff[Depth-1] && req_ff[Depth-1].operand_b == '0
      && (req_ff[Depth-1].mode == alu16_pkg::MODE_DIV
          || req_ff[Depth-1].mode == alu16_pkg::MODE_MOD)
      |=> rsp_data.zero_flag)
      else $error("zero divisor did not give zero");

endmodule
`default_nettype wire

// ===== hdl/alu16_div_pipe.sv =====
`default_nettype none
// restoring divider, StepsPerStage quotient bits per register stage
module alu16_div_pipe #(
   parameter int unsigned StepsPerStage = 4
) (
   input  wire                    clock,
   input  wire                    enable,
   input  wire [15:0]             dividend,
   input  wire [15:0]             divisor,
   output alu16_pkg::div_type     div_out
);

   localparam int unsigned Stages = 16 / StepsPerStage;

   alu16_pkg::div_type stage_ff [Stages];
   alu16_pkg::div_type stage_in [Stages];

   function automatic alu16_pkg::div_type div_steps(input alu16_pkg::div_type s);
      alu16_pkg::div_type t;
      logic [16:0] trial;
      t = s;
      for (int i = 0; i < StepsPerStage; i++) begin
         trial = {t.rem, t.quo[15]};
         t.quo = {t.quo[14:0], 1'b0};
         if (trial >= {1'b0, t.dvs}) begin
            trial = trial - {1'b0, t.dvs};
            t.quo[0] = 1'b1;
         end
         t.rem = trial[15:0];
      end
      return t;
   endfunction

   always_comb begin
      alu16_pkg::div_type s0;
      s0.rem = '0;
      s0.quo = dividend;
      s0.dvs = divisor;
      stage_in[0] = div_steps(s0);
      for (int k = 1; k < Stages; k++) begin
         stage_in[k] = div_steps(stage_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < Stages; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // quotient bits shifted through quo; remainder in rem
   assign div_out = stage_ff[Stages-1];

endmodule
`default_nettype wire

// ===== dv/alu16_with_flags_core_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module alu16_with_flags_core_tb;

   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned DrainCycles = 20;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   alu16_pkg::req_type req_data;
   logic               rsp_valid;
   alu16_pkg::rsp_type rsp_data;

   alu16_pkg::req_type pending_ops[$];
   alu16_pkg::rsp_type expected_rsp[$];
   int      idle_pct;
   int      mismatches;
   int      ops_sent;
   int      rsp_seen;
   int      cycle_count;
   bit      hold_off;

   alu16_with_flags_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic alu16_pkg::rsp_type alu_compute(alu16_pkg::req_type op);
      alu16_pkg::rsp_type r;
      logic [16:0] sum;
      logic [31:0] prod;
      logic [3:0]  amt;
      logic [31:0] wide;
      r = '0;
      amt = op.operand_b[3:0];
      case (op.mode)
         alu16_pkg::MODE_ADD: begin
            sum = {1'b0, op.operand_a} + {1'b0, op.operand_b};
            r.result = sum[15:0];
            r.carry_flag = sum[16];
            r.overflow_flag = (op.operand_a[15] == op.operand_b[15]) &&
                              (r.result[15] != op.operand_a[15]);
         end
         alu16_pkg::MODE_SUB: begin
            r.result = op.operand_a - op.operand_b;
            r.carry_flag = op.operand_a < op.operand_b;
            r.overflow_flag = (op.operand_a[15] != op.operand_b[15]) &&
                              (r.result[15] != op.operand_a[15]);
         end
         alu16_pkg::MODE_MUL: begin
            prod = op.operand_a * op.operand_b;
            r.result = prod[15:0];
            r.carry_flag = prod[31:16] != 0;
         end
         alu16_pkg::MODE_DIV:
            r.result = (op.operand_b == 0) ? '0 : op.operand_a / op.operand_b;
         alu16_pkg::MODE_MOD:
            r.result = (op.operand_b == 0) ? '0 : op.operand_a % op.operand_b;
         alu16_pkg::MODE_AND: r.result = op.operand_a & op.operand_b;
         alu16_pkg::MODE_OR:  r.result = op.operand_a | op.operand_b;
         alu16_pkg::MODE_XOR: r.result = op.operand_a ^ op.operand_b;
         alu16_pkg::MODE_NOT: r.result = ~op.operand_a;
         alu16_pkg::MODE_SHL: begin
            wide = {16'h0, op.operand_a} << amt;
            r.result = wide[15:0];
            r.carry_flag = (amt != 0) && wide[16];
         end
         alu16_pkg::MODE_SHR: begin
            r.result = op.operand_a >> amt;
            r.carry_flag = (amt != 0) && op.operand_a[amt - 1];
         end
         default: r.result = '0;
      endcase
      r.zero_flag = r.result == 0;
      r.negative_flag = r.result[15];
      return r;
   endfunction

   function automatic logic [15:0] pick_operand();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000 | 16'($urandom_range(0, 3));
         3: return 16'h7FFF - 16'($urandom_range(0, 3));
         4: return 16'($urandom_range(0, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_op(logic [3:0] mode, logic [15:0] a, logic [15:0] b);
      alu16_pkg::req_type op;
      op.mode = mode;
      op.operand_a = a;
      op.operand_b = b;
      pending_ops.push_back(op);
   endtask

   task automatic add_random_ops(int count);
      for (int i = 0; i < count; i++) begin
         add_op(($urandom_range(0, 15) == 0) ? 4'($urandom_range(11, 15))
                                             : 4'($urandom_range(0, 10)),
                pick_operand(), pick_operand());
      end
   endtask

   task automatic wait_drained();
      while (pending_ops.size() != 0 || expected_rsp.size() != 0) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
      end else begin
         if (start && !busy) begin
            expected_rsp.push_back(alu_compute(req_data));
            ops_sent <= ops_sent + 1;
         end
         if ((!start || !busy) && pending_ops.size() != 0 && !hold_off &&
             $urandom_range(0, 99) >= idle_pct) begin
            start <= 1'b1;
            req_data <= pending_ops.pop_front();
         end else if (!start || !busy) begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      alu16_pkg::rsp_type exp_rsp;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         rsp_seen <= rsp_seen + 1;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer: %p", rsp_data);
         end else begin
            exp_rsp = expected_rsp.pop_front();
            if (rsp_data !== exp_rsp) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected %p, got %p", exp_rsp, rsp_data);
               end
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      wait (cycle_count >= CycleLimit);
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      mismatches = 0;
      ops_sent = 0;
      rsp_seen = 0;
      idle_pct = 0;
      hold_off = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int m = 0; m < 16; m++) add_op(4'(m), 16'hFFFF, 16'h8001);
      add_op(alu16_pkg::MODE_ADD, 16'h7FFF, 16'h0001);
      add_op(alu16_pkg::MODE_SUB, 16'h8000, 16'h0001);
      add_op(alu16_pkg::MODE_SUB, 16'h0000, 16'h0000);
      add_op(alu16_pkg::MODE_DIV, 16'h1234, 16'h0000);
      add_op(alu16_pkg::MODE_MOD, 16'hFFFF, 16'h0000);
      add_op(alu16_pkg::MODE_MUL, 16'h0100, 16'h0100);
      add_op(alu16_pkg::MODE_SHL, 16'hABCD, 16'hFFF0);
      add_op(alu16_pkg::MODE_SHR, 16'h8001, 16'h000F);
      add_op(alu16_pkg::MODE_SHL, 16'h8001, 16'h0001);
      wait_drained();

      idle_pct = 19;
      add_random_ops(430);
      wait_drained();
      // pause until all results are back
      hold_off = 1'b1;
      add_random_ops(10);
      wait (expected_rsp.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      hold_off = 1'b0;
      idle_pct = 74;
      add_random_ops(420);
      wait_drained();
      idle_pct = 0;
      add_random_ops(440);
      wait_drained();
      repeat (DrainCycles) @(posedge clock);

      $display("sent %0d operations over all modes, operand extremes and idle mixes;",
               ops_sent);
      $display("checked %0d results, %0d mismatches", rsp_seen, mismatches);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
